[hdl/tsfc_pkg.sv]
`timescale 1ns / 1ps

package tsfc_pkg;

   localparam int PWM_FULL_SCALE_DEF = 48000;

   localparam int LEVEL_W   = 16;
   localparam int BYTE_W    = 8;
   localparam int FADE_W    = 10;
   localparam int TIME_W    = 16;
   localparam int ELAPSED_W = 17;
   localparam int BLINK_W   = 11;
   localparam int SCAN_W    = 8;
   localparam int TOUCH_W   = 16;
   localparam int COLOUR_W  = 24;
   localparam int PROD_W    = 24;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [2:0] {
      PH_STOP  = 3'd0,
      PH_GO    = 3'd1,
      PH_WARN  = 3'd2,
      PH_CROSS = 3'd3,
      PH_FADE  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      REG_STOP_TIME       = 3'd0,
      REG_GO_TIME         = 3'd1,
      REG_WARN_TIME       = 3'd2,
      REG_CROSSWALK_TIME  = 3'd3,
      REG_FADE_TIME       = 3'd4,
      REG_TOUCH_THRESHOLD = 3'd5,
      REG_SCAN_INTERVAL   = 3'd6
   } reg_idx_type;

   localparam logic [COLOUR_W-1:0] COL_STOP  = 24'h611E3C;
   localparam logic [COLOUR_W-1:0] COL_GO    = 24'h229622;
   localparam logic [COLOUR_W-1:0] COL_WARN  = 24'hFFB200;
   localparam logic [COLOUR_W-1:0] COL_CROSS = 24'h001030;
   localparam logic [COLOUR_W-1:0] COL_DARK  = 24'h000000;

   localparam logic [BLINK_W-1:0]   BLINK_OFF_MS    = 11'd250;
   localparam logic [BLINK_W-1:0]   BLINK_PERIOD_MS = 11'd1000;
   localparam logic [BLINK_W-1:0]   BLINK_MAX       = 11'd2047;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = 17'd131071;
   localparam logic [SCAN_W:0]      SCAN_MAX        = 9'd255;

   localparam logic [TIME_W-1:0]  RST_STOP_TIME       = 16'd20000;
   localparam logic [TIME_W-1:0]  RST_GO_TIME         = 16'd20000;
   localparam logic [TIME_W-1:0]  RST_WARN_TIME       = 16'd5000;
   localparam logic [TIME_W-1:0]  RST_CROSSWALK_TIME  = 16'd10000;
   localparam logic [FADE_W-1:0]  RST_FADE_TIME       = 10'd1000;
   localparam logic [TOUCH_W-1:0] RST_TOUCH_THRESHOLD = 16'd1000;
   localparam logic [SCAN_W-1:0]  RST_SCAN_INTERVAL   = 8'd50;

   typedef struct packed {
      logic [TIME_W-1:0]  stop_time;
      logic [TIME_W-1:0]  go_time;
      logic [TIME_W-1:0]  warn_time;
      logic [TIME_W-1:0]  crosswalk_time;
      logic [FADE_W-1:0]  fade_time;
      logic [TOUCH_W-1:0] touch_threshold;
      logic [SCAN_W-1:0]  scan_interval;
   } cfg_type;

   // fade = 0: drive base_col as is
   typedef struct packed {
      logic                fade;
      logic [COLOUR_W-1:0] base_col;
      logic [COLOUR_W-1:0] end_col;
      logic [FADE_W-1:0]   fade_t;
      logic [FADE_W-1:0]   fade_len;
   } level_req_type;

   function automatic logic [BYTE_W-1:0] colour_byte(input logic [COLOUR_W-1:0] col,
                                                     input logic [1:0] ch);
      case (ch)
         2'd0: begin
            return col[23:16];
         end
         2'd1: begin
            return col[15:8];
         end
         default: begin
            return col[7:0];
         end
      endcase
   endfunction

endpackage

[hdl/tsfc_csr.sv]
`timescale 1ns / 1ps

module tsfc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tsfc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tsfc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tsfc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output tsfc_pkg::cfg_type                cfg
);
   import tsfc_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[4:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_time       <= RST_STOP_TIME;
         cfg_ff.go_time         <= RST_GO_TIME;
         cfg_ff.warn_time       <= RST_WARN_TIME;
         cfg_ff.crosswalk_time  <= RST_CROSSWALK_TIME;
         cfg_ff.fade_time       <= RST_FADE_TIME;
         cfg_ff.touch_threshold <= RST_TOUCH_THRESHOLD;
         cfg_ff.scan_interval   <= RST_SCAN_INTERVAL;
      end else if (wr_en) begin
         case (idx)
            REG_STOP_TIME: begin
               cfg_ff.stop_time <= pwdata[TIME_W-1:0];
            end
            REG_GO_TIME: begin
               cfg_ff.go_time <= pwdata[TIME_W-1:0];
            end
            REG_WARN_TIME: begin
               cfg_ff.warn_time <= pwdata[TIME_W-1:0];
            end
            REG_CROSSWALK_TIME: begin
               cfg_ff.crosswalk_time <= pwdata[TIME_W-1:0];
            end
            REG_FADE_TIME: begin
               cfg_ff.fade_time <= pwdata[FADE_W-1:0];
            end
            REG_TOUCH_THRESHOLD: begin
               cfg_ff.touch_threshold <= pwdata[TOUCH_W-1:0];
            end
            REG_SCAN_INTERVAL: begin
               cfg_ff.scan_interval <= pwdata[SCAN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_STOP_TIME: begin
            prdata = CSR_DATA_W'(cfg_ff.stop_time);
         end
         REG_GO_TIME: begin
            prdata = CSR_DATA_W'(cfg_ff.go_time);
         end
         REG_WARN_TIME: begin
            prdata = CSR_DATA_W'(cfg_ff.warn_time);
         end
         REG_CROSSWALK_TIME: begin
            prdata = CSR_DATA_W'(cfg_ff.crosswalk_time);
         end
         REG_FADE_TIME: begin
            prdata = CSR_DATA_W'(cfg_ff.fade_time);
         end
         REG_TOUCH_THRESHOLD: begin
            prdata = CSR_DATA_W'(cfg_ff.touch_threshold);
         end
         REG_SCAN_INTERVAL: begin
            prdata = CSR_DATA_W'(cfg_ff.scan_interval);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

endmodule

[hdl/tsfc_divider.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; caller keeps
// dividend < divisor * 2**QW so the quotient fits in QW bits
module tsfc_divider #(
   parameter int QW = 8,
   parameter int DW = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QW+DW-1:0] dividend,
   input  logic [DW-1:0]    divisor,
   output logic             done,
   output logic [QW-1:0]    quotient
);
   localparam int CNT_W = $clog2(QW + 1);

   logic [DW-1:0]    rem_ff;
   logic [QW-1:0]    low_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DW:0] rem_sh;
   logic [DW:0] rem_sub;
   logic        ge;

   assign rem_sh   = {rem_ff, low_ff[QW-1]};
   assign rem_sub  = rem_sh - {1'b0, divisor};
   assign ge       = rem_sh >= {1'b0, divisor};
   assign done     = done_ff;
   assign quotient = low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         low_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= dividend[QW+DW-1:QW];
            low_ff  <= dividend[QW-1:0];
            cnt_ff  <= CNT_W'(QW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // quotient bits shift in where the dividend bits leave
            rem_ff <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            low_ff <= {low_ff[QW-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

[hdl/tsfc_level_unit.sv]
`timescale 1ns / 1ps

// works the three color channels one after another through one multiplier
// and the divider; holds the PWM levels between updates
module tsfc_level_unit #(
   parameter int PWM_FULL_SCALE = tsfc_pkg::PWM_FULL_SCALE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  tsfc_pkg::level_req_type             req,
   output logic                                done,
   output logic [2:0][tsfc_pkg::LEVEL_W-1:0]   levels
);
   import tsfc_pkg::*;

   localparam logic [LEVEL_W-1:0] SCALE = LEVEL_W'(PWM_FULL_SCALE);

   typedef enum logic [2:0] {
      LU_IDLE,
      LU_MUL,
      LU_DIV,
      LU_WAIT,
      LU_SCALE,
      LU_STORE
   } lu_state_type;

   lu_state_type             state_ff;
   level_req_type            req_ff;
   logic [1:0]               ch_ff;
   logic [BYTE_W-1:0]        byte_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     done_ff;
   logic [2:0][LEVEL_W-1:0]  lvl_ff;

   logic [BYTE_W-1:0]  s_byte;
   logic [BYTE_W-1:0]  e_byte;
   logic               neg;
   logic [BYTE_W-1:0]  mag;
   logic [BYTE_W-1:0]  mul_a;
   logic [LEVEL_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_out;
   logic               div_start;
   logic               div_done;
   logic [BYTE_W-1:0]  div_q;

   assign s_byte = colour_byte(req_ff.base_col, ch_ff);
   assign e_byte = colour_byte(req_ff.end_col, ch_ff);
   assign neg    = e_byte < s_byte;
   assign mag    = neg ? (s_byte - e_byte) : (e_byte - s_byte);

   // the one multiplier: |diff| * t for a fade, then byte * full scale
   assign mul_a   = (state_ff == LU_MUL) ? mag : (req_ff.fade ? byte_ff : s_byte);
   assign mul_b   = (state_ff == LU_MUL) ? LEVEL_W'(req_ff.fade_t) : SCALE;
   assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign div_start = (state_ff == LU_DIV);
   assign done      = done_ff;
   assign levels    = lvl_ff;

   tsfc_divider #(
      .QW (BYTE_W),
      .DW (FADE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[BYTE_W+FADE_W-1:0]),
      .divisor  (req_ff.fade_len),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LU_IDLE;
         req_ff   <= '0;
         ch_ff    <= '0;
         byte_ff  <= '0;
         prod_ff  <= '0;
         done_ff  <= 1'b0;
         lvl_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            LU_IDLE: begin
               if (start) begin
                  req_ff   <= req;
                  ch_ff    <= '0;
                  state_ff <= req.fade ? LU_MUL : LU_SCALE;
               end
            end
            LU_MUL: begin
               prod_ff  <= mul_out;
               state_ff <= LU_DIV;
            end
            LU_DIV: begin
               state_ff <= LU_WAIT;
            end
            LU_WAIT: begin
               if (div_done) begin
                  // signed quotient truncates toward zero: apply sign to |q|
                  byte_ff  <= neg ? (s_byte - div_q) : (s_byte + div_q);
                  state_ff <= LU_SCALE;
               end
            end
            LU_SCALE: begin
               prod_ff  <= mul_out;
               state_ff <= LU_STORE;
            end
            LU_STORE: begin
               lvl_ff[ch_ff] <= prod_ff[PROD_W-1:BYTE_W];
               if (ch_ff == 2'd2) begin
                  done_ff  <= 1'b1;
                  state_ff <= LU_IDLE;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= req_ff.fade ? LU_MUL : LU_SCALE;
               end
            end
            default: begin
               state_ff <= LU_IDLE;
            end
         endcase
      end
   end

endmodule

[hdl/traffic_signal_fade_controller_core.sv]
`timescale 1ns / 1ps

// Traffic light with fading color changes and a touch-requested crosswalk.
// req channel: one word per millisecond tick, tdata holds the touch reading.
// rsp channel: one word per tick with the held PWM compare levels for red,
// green and blue and the light phase after that tick.
// csr port: APB-style register file, seven registers at byte address 4*i.
// A tick that writes no level goes straight to the output register; when the
// crosswalk blink drives a color or while fading, the level unit runs the
// three channels in turn through one multiplier, and while fading also
// through an 8-step divider (one quotient bit per cycle).
// The block takes one word at a time; req_tready stays low from acceptance
// until the result has moved into the output register. That register lets
// the next tick be accepted while the previous result waits for rsp_tready;
// a stalled result holds its word and the block waits after computing.
// Reset puts the light in stop with all levels at zero, clears the timers
// and loads the register defaults; no result is pending after reset.
module traffic_signal_fade_controller_core #(
   parameter int PWM_FULL_SCALE = tsfc_pkg::PWM_FULL_SCALE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tsfc_pkg::REQ_DATA_W-1:0] req_tdata,   // [15:0] touch_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] red_level, [31:16] green_level, [47:32] blue_level,
   // [50:48] light_phase, [55:51] zero
   output logic [tsfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tsfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tsfc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tsfc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import tsfc_pkg::*;

   typedef enum logic [1:0] {
      T_IDLE,
      T_CALC,
      T_PUSH
   } top_state_type;

   top_state_type          state_ff;
   phase_type              phase_ff;
   phase_type              paf_ff;
   logic [COLOUR_W-1:0]    start_ff;
   logic [COLOUR_W-1:0]    end_ff;
   logic [ELAPSED_W-1:0]   pe_ff;
   logic [BLINK_W-1:0]     blink_ff;
   logic [SCAN_W-1:0]      since_ff;
   logic                   lu_start_ff;
   level_req_type          lu_req_ff;
   logic                   rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff;

   cfg_type                 cfg;
   logic                    lu_done;
   logic [2:0][LEVEL_W-1:0] levels;

   logic [TOUCH_W-1:0]   touch;
   logic [SCAN_W:0]      scan_count;
   logic [ELAPSED_W-1:0] pe_inc;
   logic [BLINK_W-1:0]   blink_inc;
   logic                 scan_due;
   logic                 touch_hit;
   phase_type            ph_scan;
   phase_type            paf_scan;
   logic [COLOUR_W-1:0]  end_scan;
   logic [ELAPSED_W-1:0] pe_scan;
   logic                 rsp_load;

   phase_type            phase_n;
   phase_type            paf_n;
   logic [COLOUR_W-1:0]  start_n;
   logic [COLOUR_W-1:0]  end_n;
   logic [ELAPSED_W-1:0] pe_n;
   logic [BLINK_W-1:0]   blink_n;
   logic [SCAN_W-1:0]    since_n;
   logic                 lu_go_n;
   level_req_type        lu_req_n;

   tsfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tsfc_level_unit #(
      .PWM_FULL_SCALE (PWM_FULL_SCALE)
   ) u_level (
      .clock  (clock),
      .reset  (reset),
      .start  (lu_start_ff),
      .req    (lu_req_ff),
      .done   (lu_done),
      .levels (levels)
   );

   assign touch      = req_tdata[TOUCH_W-1:0];
   assign req_tready = (state_ff == T_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // output word free or leaving this cycle
   assign rsp_load = (state_ff == T_PUSH) && (!rsp_tvalid_ff || rsp_tready);

   // phase update for one tick
   always_comb begin
      scan_count = {1'b0, since_ff} + 9'd1;
      pe_inc     = (pe_ff == ELAPSED_MAX) ? pe_ff : pe_ff + 1'b1;
      blink_inc  = (blink_ff == BLINK_MAX) ? blink_ff : blink_ff + 1'b1;
      scan_due   = (phase_ff != PH_CROSS) && (paf_ff != PH_CROSS) &&
                   (scan_count > {1'b0, cfg.scan_interval});
      touch_hit  = scan_due && (touch > cfg.touch_threshold);

      if (scan_due) begin
         since_n = '0;
      end else if (scan_count > SCAN_MAX) begin
         since_n = SCAN_MAX[SCAN_W-1:0];
      end else begin
         since_n = scan_count[SCAN_W-1:0];
      end

      ph_scan  = touch_hit ? PH_FADE : phase_ff;
      paf_scan = touch_hit ? PH_CROSS : paf_ff;
      end_scan = touch_hit ? COL_CROSS : end_ff;
      pe_scan  = touch_hit ? '0 : pe_inc;

      phase_n  = ph_scan;
      paf_n    = paf_scan;
      start_n  = start_ff;
      end_n    = end_scan;
      pe_n     = pe_scan;
      blink_n  = blink_inc;
      lu_go_n  = 1'b0;
      lu_req_n = '{fade: 1'b0, base_col: start_ff, end_col: end_scan,
                   fade_t: pe_scan[FADE_W-1:0], fade_len: cfg.fade_time};

      case (ph_scan)
         PH_STOP: begin
            start_n = COL_STOP;
            if (pe_scan >= {1'b0, cfg.stop_time}) begin
               phase_n = PH_FADE;
               end_n   = COL_GO;
               paf_n   = PH_GO;
               pe_n    = '0;
            end
         end
         PH_GO: begin
            start_n = COL_GO;
            if (pe_scan >= {1'b0, cfg.go_time}) begin
               phase_n = PH_FADE;
               end_n   = COL_WARN;
               paf_n   = PH_WARN;
               pe_n    = '0;
            end
         end
         PH_WARN: begin
            start_n = COL_WARN;
            if (pe_scan >= {1'b0, cfg.warn_time}) begin
               phase_n = PH_FADE;
               end_n   = COL_STOP;
               paf_n   = PH_STOP;
               pe_n    = '0;
            end
         end
         PH_CROSS: begin
            start_n = COL_CROSS;
            if (pe_scan <= {1'b0, cfg.crosswalk_time}) begin
               if (blink_inc <= BLINK_OFF_MS) begin
                  lu_go_n           = 1'b1;
                  lu_req_n.base_col = COL_DARK;
               end else if (blink_inc <= BLINK_PERIOD_MS) begin
                  lu_go_n           = 1'b1;
                  lu_req_n.base_col = COL_CROSS;
               end else begin
                  blink_n = '0;
               end
            end else begin
               phase_n = PH_FADE;
               end_n   = COL_GO;
               paf_n   = PH_GO;
               pe_n    = '0;
            end
         end
         PH_FADE: begin
            if ((pe_scan < ELAPSED_W'(cfg.fade_time)) && (cfg.fade_time != '0)) begin
               lu_go_n       = 1'b1;
               lu_req_n.fade = 1'b1;
            end else begin
               phase_n = (paf_scan > PH_FADE) ? PH_FADE : paf_scan;
               pe_n    = '0;
               if (phase_n == PH_CROSS) begin
                  blink_n = '0;
               end
            end
         end
         default: begin
            phase_n = PH_STOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         phase_ff      <= PH_STOP;
         paf_ff        <= PH_FADE;
         start_ff      <= COL_STOP;
         end_ff        <= COL_STOP;
         pe_ff         <= '0;
         blink_ff      <= '0;
         since_ff      <= '0;
         lu_start_ff   <= 1'b0;
         lu_req_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tdata_ff  <= '0;
      end else begin
         lu_start_ff <= (state_ff == T_IDLE) && req_tvalid && lu_go_n;
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff  <= {5'b0, phase_ff, levels[2], levels[1], levels[0]};
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            T_IDLE: begin
               if (req_tvalid) begin
                  phase_ff  <= phase_n;
                  paf_ff    <= paf_n;
                  start_ff  <= start_n;
                  end_ff    <= end_n;
                  pe_ff     <= pe_n;
                  blink_ff  <= blink_n;
                  since_ff  <= since_n;
                  lu_req_ff <= lu_req_n;
                  if (lu_go_n) begin
                     state_ff <= T_CALC;
                  end else begin
                     state_ff <= T_PUSH;
                  end
               end
            end
            T_CALC: begin
               if (lu_done) begin
                  state_ff <= T_PUSH;
               end
            end
            T_PUSH: begin
               if (rsp_load) begin
                  state_ff <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

endmodule

[hdl/tsfc_checker.sv]
`timescale 1ns / 1ps

module tsfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tsfc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // one tick at a time: not ready right after taking a word
   a_req_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken on back-to-back cycles");

   // light phase code stays within stop..fading
   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[50:48] != 3'd5) && (rsp_tdata[50:48] != 3'd6) &&
                     (rsp_tdata[50:48] != 3'd7))
      else $error("bad light phase code");

   // nothing pending once reset has been seen
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind traffic_signal_fade_controller_core tsfc_checker u_tsfc_checker (.*);

[tb/sv/traffic_signal_fade_controller_core_test.sv]
`timescale 1ns / 1ps

module traffic_signal_fade_controller_core_test;

   import tsfc_pkg::*;

   typedef struct {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      phase_type          phase;
   } light_word_type;

   localparam logic [TOUCH_W-1:0] OPENING_TOUCH [18] = '{
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd999, 16'd1000,
      16'd1001, 16'd1001, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535,
      16'h5555, 16'hAAAA
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [15:0] touch_value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] red_level, [31:16] green_level, [47:32] blue_level,
   // [50:48] light_phase, [55:51] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [TOUCH_W-1:0] touch_pending [$];
   light_word_type     due_words [$];
   int                 mismatches = 0;
   int                 idle_pct = 24;
   int                 hold_asked = 0;
   int                 hold_done = 0;
   int                 hold_left = 0;

   // light state mirrored by the testbench model
   cfg_type               light_cfg;
   phase_type             cur_phase;
   phase_type             after_fade;
   logic [COLOUR_W-1:0]   fade_from;
   logic [COLOUR_W-1:0]   fade_to;
   logic [ELAPSED_W-1:0]  phase_ms;
   logic [SCAN_W-1:0]     scan_ms;
   logic [BLINK_W-1:0]    blink_ms;
   logic [LEVEL_W-1:0]    lvl_red;
   logic [LEVEL_W-1:0]    lvl_green;
   logic [LEVEL_W-1:0]    lvl_blue;

   traffic_signal_fade_controller_core DUT (.*);

   always #1 clock = ~clock;

   function automatic void restart_light();
      light_cfg.stop_time       = RST_STOP_TIME;
      light_cfg.go_time         = RST_GO_TIME;
      light_cfg.warn_time       = RST_WARN_TIME;
      light_cfg.crosswalk_time  = RST_CROSSWALK_TIME;
      light_cfg.fade_time       = RST_FADE_TIME;
      light_cfg.touch_threshold = RST_TOUCH_THRESHOLD;
      light_cfg.scan_interval   = RST_SCAN_INTERVAL;
      cur_phase  = PH_STOP;
      after_fade = PH_FADE;
      fade_from  = COL_STOP;
      fade_to    = COL_STOP;
      phase_ms   = '0;
      scan_ms    = '0;
      blink_ms   = '0;
      lvl_red    = '0;
      lvl_green  = '0;
      lvl_blue   = '0;
   endfunction

   function automatic logic [LEVEL_W-1:0] pwm_level(input logic [BYTE_W-1:0] c);
      int unsigned p;
      p = c * PWM_FULL_SCALE_DEF / 256;
      return p[LEVEL_W-1:0];
   endfunction

   function automatic void drive_rgb(input logic [COLOUR_W-1:0] col);
      lvl_red   = pwm_level(col[23:16]);
      lvl_green = pwm_level(col[15:8]);
      lvl_blue  = pwm_level(col[7:0]);
   endfunction

   // linear blend, quotient truncated toward zero
   function automatic logic [BYTE_W-1:0] blend_byte(input logic [BYTE_W-1:0] s,
                                                    input logic [BYTE_W-1:0] e,
                                                    input int t, input int d);
      int diff;
      int v;
      diff = int'(e) - int'(s);
      v = diff * t / d + int'(s);
      return v[BYTE_W-1:0];
   endfunction

   function automatic void fade_towards(input logic [COLOUR_W-1:0] col,
                                        input phase_type nxt);
      cur_phase  = PH_FADE;
      fade_to    = col;
      after_fade = nxt;
      phase_ms   = '0;
   endfunction

   function automatic light_word_type advance_light(input logic [TOUCH_W-1:0] touch);
      int             scan_next;
      int             t;
      int             d;
      light_word_type w;
      scan_next = int'(scan_ms) + 1;
      if (phase_ms < ELAPSED_MAX) begin
         phase_ms++;
      end
      if (blink_ms < BLINK_MAX) begin
         blink_ms++;
      end
      // no touch scan inside the crosswalk or on the way to it
      if (cur_phase != PH_CROSS && after_fade != PH_CROSS &&
          scan_next > int'(light_cfg.scan_interval)) begin
         if (touch > light_cfg.touch_threshold) begin
            fade_towards(COL_CROSS, PH_CROSS);
         end
         scan_ms = '0;
      end else begin
         scan_ms = (scan_next > int'(SCAN_MAX)) ? SCAN_W'(SCAN_MAX) : SCAN_W'(scan_next);
      end
      case (cur_phase)
         PH_STOP: begin
            fade_from = COL_STOP;
            if (phase_ms >= light_cfg.stop_time) begin
               fade_towards(COL_GO, PH_GO);
            end
         end
         PH_GO: begin
            fade_from = COL_GO;
            if (phase_ms >= light_cfg.go_time) begin
               fade_towards(COL_WARN, PH_WARN);
            end
         end
         PH_WARN: begin
            fade_from = COL_WARN;
            if (phase_ms >= light_cfg.warn_time) begin
               fade_towards(COL_STOP, PH_STOP);
            end
         end
         PH_CROSS: begin
            fade_from = COL_CROSS;
            if (phase_ms <= light_cfg.crosswalk_time) begin
               if (blink_ms <= BLINK_OFF_MS) begin
                  drive_rgb(COL_DARK);
               end else if (blink_ms <= BLINK_PERIOD_MS) begin
                  drive_rgb(COL_CROSS);
               end else begin
                  blink_ms = '0;
               end
            end else begin
               fade_towards(COL_GO, PH_GO);
            end
         end
         PH_FADE: begin
            if (phase_ms < light_cfg.fade_time && light_cfg.fade_time != 0) begin
               t = phase_ms;
               d = light_cfg.fade_time;
               drive_rgb({blend_byte(fade_from[23:16], fade_to[23:16], t, d),
                          blend_byte(fade_from[15:8], fade_to[15:8], t, d),
                          blend_byte(fade_from[7:0], fade_to[7:0], t, d)});
            end else begin
               cur_phase = after_fade;
               phase_ms  = '0;
               if (cur_phase == PH_CROSS) begin
                  blink_ms = '0;
               end
            end
         end
         default: begin
            cur_phase = PH_STOP;
         end
      endcase
      w.red   = lvl_red;
      w.green = lvl_green;
      w.blue  = lvl_blue;
      w.phase = cur_phase;
      return w;
   endfunction

   function automatic logic [TOUCH_W-1:0] pick_touch(input int hi_pct);
      int unsigned thr;
      thr = light_cfg.touch_threshold;
      if ($urandom_range(99) < hi_pct && thr < 65535) begin
         return TOUCH_W'($urandom_range(65535, thr + 1));
      end
      return TOUCH_W'($urandom_range(thr, 0));
   endfunction

   task automatic csr_write(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_STOP_TIME: begin
            light_cfg.stop_time = val[TIME_W-1:0];
         end
         REG_GO_TIME: begin
            light_cfg.go_time = val[TIME_W-1:0];
         end
         REG_WARN_TIME: begin
            light_cfg.warn_time = val[TIME_W-1:0];
         end
         REG_CROSSWALK_TIME: begin
            light_cfg.crosswalk_time = val[TIME_W-1:0];
         end
         REG_FADE_TIME: begin
            light_cfg.fade_time = val[FADE_W-1:0];
         end
         REG_TOUCH_THRESHOLD: begin
            light_cfg.touch_threshold = val[TOUCH_W-1:0];
         end
         REG_SCAN_INTERVAL: begin
            light_cfg.scan_interval = val[SCAN_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_timing(input int stop_ms, input int go_ms, input int warn_ms,
                             input int cross_ms, input int fade_ms, input int threshold,
                             input int scan_gap);
      csr_write(REG_STOP_TIME, stop_ms);
      csr_write(REG_GO_TIME, go_ms);
      csr_write(REG_WARN_TIME, warn_ms);
      csr_write(REG_CROSSWALK_TIME, cross_ms);
      csr_write(REG_FADE_TIME, fade_ms);
      csr_write(REG_TOUCH_THRESHOLD, threshold);
      csr_write(REG_SCAN_INTERVAL, scan_gap);
   endtask

   task automatic feed_touch(input int count, input int hi_pct);
      repeat (count) touch_pending.push_back(pick_touch(hi_pct));
   endtask

   // wait until every word is in and out, then let the block settle
   task automatic wait_settled(input int extra);
      do begin
         @(negedge clock);
      end while (touch_pending.size() != 0 || req_tvalid || due_words.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_words.push_back(advance_light(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (touch_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= touch_pending.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_done) begin
         hold_done  <= hold_asked;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : watch_rsp
      light_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected rsp word %h", rsp_tdata);
            end
         end else begin
            want = due_words.pop_front();
            if (rsp_tdata[15:0] !== want.red || rsp_tdata[31:16] !== want.green ||
                rsp_tdata[47:32] !== want.blue || rsp_tdata[50:48] !== want.phase) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("rsp mismatch: got r=%0d g=%0d b=%0d phase=%0d",
                           rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                           rsp_tdata[50:48]);
                  $display("              want r=%0d g=%0d b=%0d phase=%0d",
                           want.red, want.green, want.blue, want.phase);
               end
            end
         end
      end
   end

   initial begin
      restart_light();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short cycle, threshold edges, touch during a fade
      set_timing(2, 2, 1, 3, 3, 1000, 1);
      foreach (OPENING_TOUCH[i]) touch_pending.push_back(OPENING_TOUCH[i]);
      wait_settled(64);

      // zero fade time, any touch requests the crosswalk
      set_timing(1, 1, 1, 2, 0, 0, 0);
      touch_pending.push_back(16'd1);
      repeat (6) touch_pending.push_back(16'd0);
      wait_settled(64);

      // receiver holds off while words keep coming, then sender pauses
      set_timing(5, 6, 3, 40, 4, 2000, 7);
      hold_asked++;
      feed_touch(30, 10);
      wait_settled(0);
      feed_touch(30, 10);
      wait_settled(64);

      // shortest timings with no idling on either side
      idle_pct = 0;
      set_timing(1, 1, 1, 1, 1, 0, 0);
      feed_touch(40, 50);
      wait_settled(64);
      idle_pct = 24;

      // crosswalk long enough for the blink to turn on
      set_timing(10, 10, 10, 1010, 1, 0, 0);
      touch_pending.push_back(16'd1);
      feed_touch(270, 15);
      wait_settled(64);

      // longest phase timings and scan interval
      set_timing(65535, 65535, 65535, 65535, 1000, 65535, 255);
      feed_touch(8, 0);
      wait_settled(64);

      // long fade interrupted by a touch
      set_timing(3, 65535, 2, 65535, 1000, 40000, 10);
      feed_touch(30, 50);
      wait_settled(64);

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
